### src/rloc_pkg.sv
`timescale 1ns / 1ps

package rloc_pkg;

  localparam int CHANNELS  = 8;
  localparam int CH_W      = 3;
  localparam int COUNT_W   = 4;
  localparam int VER_W     = 32;
  localparam int TAG_W     = 16;
  localparam int TIME_W    = 32;
  localparam int IVL_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;
  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 64;
  localparam int STATUS_W  = 3;
  localparam int QDEPTH    = 2;
  localparam int QCNT_W    = 2;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_UNMAPPED,
    KIND_TICK
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_APPLIED  = 3'd0,
    STATUS_DEFERRED = 3'd1,
    STATUS_STALE    = 3'd2,
    STATUS_UNMAPPED = 3'd3,
    STATUS_NONE_DUE = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT = 2'd0,
    CFG_ACTIVE_HIGH   = 2'd1,
    CFG_INTERVAL_LO   = 2'd2,
    CFG_INTERVAL_HI   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    kind_e             kind;
    logic [CH_W-1:0]   channel;
    logic              value;
    logic [VER_W-1:0]  version;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] now_ms;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [CH_W-1:0]   channel;
    logic              value;
    logic [VER_W-1:0]  acked_version;
    logic [TAG_W-1:0]  tag;
    logic [CHANNELS-1:0] pin_levels;
    logic              last;
  } result_t;

endpackage

### src/rloc_front.sv
`timescale 1ns / 1ps

module rloc_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [rloc_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic                             s_tuser,
  input  logic [rloc_pkg::COUNT_W-1:0]     used_i,
  output logic                             q_valid_o,
  output rloc_pkg::cmd_t                   q_data_o,
  input  logic                             q_pop_i
);

  rloc_pkg::cmd_t              entry_q [rloc_pkg::QDEPTH];
  rloc_pkg::cmd_t              cmd;
  logic                        wr_ptr_q, rd_ptr_q;
  logic [rloc_pkg::QCNT_W-1:0] count_q;
  logic                        push, pop;

  // Classify the beat on the way in.
  always_comb begin
    cmd.channel = s_tdata[2:0];
    cmd.value   = s_tdata[3];
    cmd.version = s_tdata[35:4];
    cmd.tag     = s_tdata[51:36];
    cmd.now_ms  = s_tdata[83:52];
    if (s_tuser == rloc_pkg::OP_TICK) begin
      cmd.kind = rloc_pkg::KIND_TICK;
    end else if ({1'b0, cmd.channel} >= used_i) begin
      cmd.kind = rloc_pkg::KIND_UNMAPPED;
    end else begin
      cmd.kind = rloc_pkg::KIND_WRITE;
    end
  end

  assign s_tready  = (count_q != rloc_pkg::QCNT_W'(rloc_pkg::QDEPTH));
  assign push      = s_tvalid && s_tready;
  assign pop       = q_pop_i && (count_q != '0);
  assign q_valid_o = (count_q != '0);
  assign q_data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rloc_pkg::QCNT_W'(rloc_pkg::QDEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 && push) |=> (count_q == rloc_pkg::QCNT_W'(1)))
    else $error("push into empty queue lost");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == rloc_pkg::QCNT_W'(rloc_pkg::QDEPTH)) |-> !s_tready)
    else $error("queue ready while full");

endmodule

### src/rloc_back.sv
`timescale 1ns / 1ps

module rloc_back (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          q_valid_i,
  input  rloc_pkg::cmd_t                                q_data_i,
  output logic                                          q_pop_o,
  input  logic [rloc_pkg::COUNT_W-1:0]                  used_i,
  input  logic [rloc_pkg::CHANNELS-1:0]                 high_mask_i,
  input  logic [rloc_pkg::CHANNELS*rloc_pkg::IVL_W-1:0] intervals_i,
  output logic                                          res_valid_o,
  input  logic                                          res_ready_i,
  output rloc_pkg::result_t                             res_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  localparam int N = rloc_pkg::CHANNELS;

  state_e                          state_q, state_d;
  logic [N-1:0]                    applied_q, applied_d;
  logic [N-1:0]                    ever_q, ever_d;
  logic [N-1:0]                    pend_q, pend_d;
  logic [N-1:0]                    pend_val_q, pend_val_d;
  logic [rloc_pkg::TIME_W-1:0]     lat_q [N];
  logic [rloc_pkg::TIME_W-1:0]     lat_d [N];
  logic [rloc_pkg::VER_W-1:0]      lsv_q [N];
  logic [rloc_pkg::VER_W-1:0]      lsv_d [N];
  logic [rloc_pkg::TAG_W-1:0]      ptag_q [N];
  logic [rloc_pkg::TAG_W-1:0]      ptag_d [N];
  logic [N-1:0]                    mask_q, mask_d;
  logic [rloc_pkg::TIME_W-1:0]     now_q, now_d;
  logic                            out_valid_q, out_valid_d;
  rloc_pkg::result_t               out_q, out_d;

  logic [rloc_pkg::IVL_W-1:0]      ivl [N];
  logic [N-1:0]                    due;
  logic [N-1:0]                    sel_oh;
  logic [rloc_pkg::CH_W-1:0]       sel;
  logic [rloc_pkg::CH_W-1:0]       hch;
  logic [rloc_pkg::TIME_W-1:0]     elapsed;
  logic                            stale, ready_now, out_free, emit;

  assign out_free = !out_valid_q || res_ready_i;
  assign hch      = q_data_i.channel;

  // Per-channel due test against the queued tick time.
  always_comb begin
    for (int c = 0; c < N; c++) begin
      ivl[c] = intervals_i[rloc_pkg::IVL_W*c +: rloc_pkg::IVL_W];
      due[c] = (rloc_pkg::COUNT_W'(c) < used_i) && pend_q[c] &&
               ((q_data_i.now_ms - lat_q[c]) >= {16'b0, ivl[c]});
    end
  end

  assign elapsed   = q_data_i.now_ms - lat_q[hch];
  assign stale     = (q_data_i.version != '0) && (q_data_i.version <= lsv_q[hch]);
  assign ready_now = !ever_q[hch] || (elapsed >= {16'b0, ivl[hch]});

  // Lowest pending channel of the scan.
  assign sel_oh = mask_q & (~mask_q + 1'b1);
  always_comb begin
    sel = '0;
    for (int c = N - 1; c >= 0; c--) begin
      if (mask_q[c]) begin
        sel = rloc_pkg::CH_W'(c);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    applied_d   = applied_q;
    ever_d      = ever_q;
    pend_d      = pend_q;
    pend_val_d  = pend_val_q;
    lat_d       = lat_q;
    lsv_d       = lsv_q;
    ptag_d      = ptag_q;
    mask_d      = mask_q;
    now_d       = now_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_ready_i;
    q_pop_o     = 1'b0;
    emit        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o           = 1'b1;
          out_d.channel       = hch;
          out_d.tag           = q_data_i.tag;
          out_d.last          = 1'b1;
          out_d.acked_version = '0;
          case (q_data_i.kind)
            rloc_pkg::KIND_UNMAPPED: begin
              emit         = 1'b1;
              out_d.status = rloc_pkg::STATUS_UNMAPPED;
              out_d.value  = 1'b0;
            end
            rloc_pkg::KIND_WRITE: begin
              emit = 1'b1;
              if (stale) begin
                out_d.status = rloc_pkg::STATUS_STALE;
                out_d.value  = applied_q[hch];
              end else if (ready_now) begin
                applied_d[hch]      = q_data_i.value;
                ever_d[hch]         = 1'b1;
                pend_d[hch]         = 1'b0;
                lat_d[hch]          = q_data_i.now_ms;
                lsv_d[hch]          = q_data_i.version;
                out_d.status        = rloc_pkg::STATUS_APPLIED;
                out_d.value         = q_data_i.value;
                out_d.acked_version = q_data_i.version;
              end else begin
                pend_d[hch]     = 1'b1;
                pend_val_d[hch] = q_data_i.value;
                ptag_d[hch]     = q_data_i.tag;
                lsv_d[hch]      = q_data_i.version;
                out_d.status    = rloc_pkg::STATUS_DEFERRED;
                out_d.value     = q_data_i.value;
              end
            end
            rloc_pkg::KIND_TICK: begin
              mask_d  = due;
              now_d   = q_data_i.now_ms;
              state_d = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          emit = 1'b1;
          if (mask_q == '0) begin
            out_d.status        = rloc_pkg::STATUS_NONE_DUE;
            out_d.channel       = '0;
            out_d.value         = 1'b0;
            out_d.acked_version = '0;
            out_d.tag           = '0;
            out_d.last          = 1'b1;
            state_d             = ST_IDLE;
          end else begin
            applied_d[sel]      = pend_val_q[sel];
            ever_d[sel]         = 1'b1;
            pend_d[sel]         = 1'b0;
            lat_d[sel]          = now_q;
            ptag_d[sel]         = '0;
            mask_d              = mask_q & ~sel_oh;
            out_d.status        = rloc_pkg::STATUS_APPLIED;
            out_d.channel       = sel;
            out_d.value         = pend_val_q[sel];
            out_d.acked_version = lsv_q[sel];
            out_d.tag           = ptag_q[sel];
            out_d.last          = ((mask_q & ~sel_oh) == '0);
            if ((mask_q & ~sel_oh) == '0) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (emit) begin
      out_valid_d      = 1'b1;
      out_d.pin_levels = ~(applied_d ^ high_mask_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      applied_q   <= '0;
      ever_q      <= '0;
      pend_q      <= '0;
      pend_val_q  <= '0;
      lat_q       <= '{default: '0};
      lsv_q       <= '{default: '0};
      ptag_q      <= '{default: '0};
      mask_q      <= '0;
      now_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      applied_q   <= applied_d;
      ever_q      <= ever_d;
      pend_q      <= pend_d;
      pend_val_q  <= pend_val_d;
      lat_q       <= lat_d;
      lsv_q       <= lsv_d;
      ptag_q      <= ptag_d;
      mask_q      <= mask_d;
      now_q       <= now_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  a_scan_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ((mask_q & ~pend_q) == '0))
    else $error("scan mask names a channel with nothing pending");

  a_applied_ever: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == rloc_pkg::STATUS_APPLIED) |-> ever_q[out_q.channel])
    else $error("applied result on a channel never marked applied");

  a_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.last) |-> (state_q == ST_SCAN))
    else $error("non-final result outside a tick scan");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && out_free && mask_q == '0) |=> (state_q == ST_IDLE))
    else $error("empty scan did not return to idle");

endmodule

### src/rate_limited_output_commands_top.sv
`timescale 1ns / 1ps

// Channel   | Dir | Handshake                  | Beat content
// ----------+-----+----------------------------+---------------------------------------
// s_*       | in  | s_tvalid / s_tready        | tuser operation; tdata command fields
// m_*       | out | m_tvalid / m_tready        | tuser status; tdata result; tlast final
// cfg_*     | in  | cfg_valid_i / cfg_ready_o  | cfg_index_i register, cfg_data_i value
//
// A write command passes through the front queue and then the back unit, which
// reads and updates the channel state and registers the result beat.
// A tick passes through the front queue, then the back unit samples all due
// tests into its scan mask and gives one result per cycle from its output
// register while m_tready allows, one per due channel or one if none is due.
// The two-entry queue keeps accepting until full while the back stalls on m_tready.
// Reset clears all channel state and config (high mask to ones); no clearing pass.

module rate_limited_output_commands_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [2:0] channel, [3] value, [35:4] version, [51:36] request_tag,
  // [83:52] now_ms, [87:84] zero
  input  logic [rloc_pkg::S_TDATA_W-1:0]      s_tdata,
  // [0] operation
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [2:0] out_channel, [3] out_value, [35:4] acked_version, [51:36] out_tag,
  // [59:52] pin_levels, [63:60] zero
  output logic [rloc_pkg::M_TDATA_W-1:0]      m_tdata,
  // [2:0] status
  output logic [rloc_pkg::STATUS_W-1:0]       m_tuser,
  output logic                                m_tlast,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rloc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rloc_pkg::CFG_W-1:0]          cfg_data_i
);

  logic [rloc_pkg::COUNT_W-1:0]      count_q;
  logic [rloc_pkg::CHANNELS-1:0]     high_mask_q;
  logic [rloc_pkg::CFG_W-1:0]        ivl_lo_q, ivl_hi_q;
  logic [rloc_pkg::COUNT_W-1:0]      used;
  logic                              q_valid, q_pop;
  rloc_pkg::cmd_t                    q_data;
  rloc_pkg::result_t                 res;

  // Configuration always taken; user writes only while the block is idle, unenforced.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      high_mask_q <= '1;
      ivl_lo_q    <= '0;
      ivl_hi_q    <= '0;
    end else if (cfg_valid_i) begin
      case (rloc_pkg::cfg_idx_e'(cfg_index_i))
        rloc_pkg::CFG_CHANNEL_COUNT: count_q     <= cfg_data_i[rloc_pkg::COUNT_W-1:0];
        rloc_pkg::CFG_ACTIVE_HIGH:   high_mask_q <= cfg_data_i[rloc_pkg::CHANNELS-1:0];
        rloc_pkg::CFG_INTERVAL_LO:   ivl_lo_q    <= cfg_data_i;
        rloc_pkg::CFG_INTERVAL_HI:   ivl_hi_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the channel count to the channels that exist.
  assign used = (count_q > rloc_pkg::COUNT_W'(rloc_pkg::CHANNELS)) ?
                rloc_pkg::COUNT_W'(rloc_pkg::CHANNELS) : count_q;

  // Front: take beats, tag them write, unmapped or tick, and queue them.
  rloc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .used_i    (used),
    .q_valid_o (q_valid),
    .q_data_o  (q_data),
    .q_pop_i   (q_pop)
  );

  // Back: hold channel state, apply, defer or drop, and scan on ticks.
  rloc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .used_i      (used),
    .high_mask_i (high_mask_q),
    .intervals_i ({ivl_hi_q, ivl_lo_q}),
    .res_valid_o (m_tvalid),
    .res_ready_i (m_tready),
    .res_o       (res)
  );

  // Pack the result beat.
  assign m_tdata = {4'b0, res.pin_levels, res.tag, res.acked_version, res.value, res.channel};
  assign m_tuser = res.status;
  assign m_tlast = res.last;

endmodule

### tb/tb_rate_limited_output_commands_top.sv
`timescale 1ns / 1ps

module tb_rate_limited_output_commands_top;

  import rloc_pkg::*;

  // Cycles without any beat on any channel before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Cycles to let pass after the last result before touching registers or ending.
  localparam int unsigned DRAIN_CYCLES = 12;
  // Mismatch lines printed before going quiet (they are still counted).
  localparam int unsigned PRINT_CAP = 40;

  // One command or tick as presented on the slave side.
  typedef struct {
    op_e         op;
    logic [2:0]  ch;
    logic        val;
    logic [31:0] ver;
    logic [15:0] tag;
    logic [31:0] now;
  } command_beat_t;

  // One expected acknowledgement beat on the master side.
  typedef struct {
    status_e     status;
    logic [2:0]  ch;
    logic        val;
    logic [31:0] ver;
    logic [15:0] tag;
    logic [7:0]  pins;
    logic        last;
  } ack_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_tvalid    = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata     = '0;
  logic                 s_tuser     = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready    = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]  m_tuser;
  logic                 m_tlast;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;

  rate_limited_output_commands_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: configuration and per-channel state, updated as beats
  // are accepted so that it tracks the block exactly.
  // ---------------------------------------------------------------------------
  logic [3:0]  cfg_count    = 4'd0;
  logic [7:0]  cfg_polarity = 8'hFF;
  logic [63:0] gap_lo       = '0;
  logic [63:0] gap_hi       = '0;

  logic [7:0]  lvl       = '0;   // applied on/off per channel
  logic [7:0]  ever_set  = '0;   // channel has been applied at least once
  logic [7:0]  hold      = '0;   // a deferred command waits on the channel
  logic [7:0]  hold_val  = '0;
  logic [15:0] hold_tag  [8] = '{default: '0};
  logic [31:0] set_time  [8] = '{default: '0};
  logic [31:0] seen_ver  [8] = '{default: '0};

  ack_t          ack_queue [$];
  command_beat_t cmd_queue [$];

  string field_name [7] = '{"status", "channel", "value", "acked_version", "tag",
                            "pin_levels", "last"};

  int unsigned error_count = 0;
  int unsigned n_writes    = 0;
  int unsigned n_ticks     = 0;
  int unsigned status_seen [5] = '{default: 0};

  bit          s_taken = 1'b0;   // slave beat accepted at the last rising edge
  bit          idle_on = 1'b1;   // random gaps on both sides when set
  int unsigned send_wait  = 0;
  int unsigned stall_left = 0;

  // Stimulus-side bookkeeping.
  logic [31:0] clock_ms = '0;
  logic [31:0] issued_ver [8] = '{default: '0};

  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= PRINT_CAP) $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  function automatic logic [15:0] min_gap(int unsigned c);
    logic [63:0] lane_word;
    lane_word = (c < 4) ? gap_lo : gap_hi;
    return lane_word[(c % 4) * 16 +: 16];
  endfunction

  function automatic void expect_ack(status_e st, logic [2:0] ch, logic val,
                                     logic [31:0] ver, logic [15:0] tag, logic last);
    ack_t a;
    a.status = st;
    a.ch     = ch;
    a.val    = val;
    a.ver    = ver;
    a.tag    = tag;
    a.pins   = ~(lvl ^ cfg_polarity);   // levels after any apply done so far
    a.last   = last;
    ack_queue.push_back(a);
  endfunction

  function automatic void commit(int unsigned c, logic val, logic [31:0] now);
    lvl[c]      = val;
    ever_set[c] = 1'b1;
    hold[c]     = 1'b0;
    set_time[c] = now;
  endfunction

  // Work out the acknowledgements one accepted beat causes, in order.
  function automatic void predict_acks(command_beat_t b);
    int unsigned lanes;
    int unsigned due;
    logic [31:0] age;
    lanes = (cfg_count > CHANNELS) ? CHANNELS : cfg_count;
    if (b.op == OP_WRITE) begin
      age = b.now - set_time[b.ch];
      if (b.ch >= lanes) begin
        expect_ack(STATUS_UNMAPPED, b.ch, 1'b0, '0, b.tag, 1'b1);
      end else if (b.ver != 0 && b.ver <= seen_ver[b.ch]) begin
        expect_ack(STATUS_STALE, b.ch, lvl[b.ch], '0, b.tag, 1'b1);
      end else if (!ever_set[b.ch] || age >= {16'd0, min_gap(b.ch)}) begin
        commit(b.ch, b.val, b.now);
        seen_ver[b.ch] = b.ver;
        expect_ack(STATUS_APPLIED, b.ch, b.val, b.ver, b.tag, 1'b1);
      end else begin
        // Defer: replace whatever was waiting, and take the version now.
        hold[b.ch]     = 1'b1;
        hold_val[b.ch] = b.val;
        hold_tag[b.ch] = b.tag;
        seen_ver[b.ch] = b.ver;
        expect_ack(STATUS_DEFERRED, b.ch, b.val, '0, b.tag, 1'b1);
      end
    end else begin
      due = 0;
      for (int unsigned c = 0; c < lanes; c++) begin
        age = b.now - set_time[c];
        if (hold[c] && age >= {16'd0, min_gap(c)}) begin
          commit(c, hold_val[c], b.now);
          expect_ack(STATUS_APPLIED, 3'(c), lvl[c], seen_ver[c], hold_tag[c], 1'b0);
          hold_tag[c] = '0;
          due++;
        end
      end
      if (due == 0) begin
        expect_ack(STATUS_NONE_DUE, 3'd0, 1'b0, '0, '0, 1'b1);
      end else begin
        // Mark the final acknowledgement of the tick.
        ack_t tail;
        tail      = ack_queue.pop_back();
        tail.last = 1'b1;
        ack_queue.push_back(tail);
      end
    end
  endfunction

  task automatic check_ack();
    ack_t        want;
    logic [31:0] got_f  [7];
    logic [31:0] want_f [7];
    if (ack_queue.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing expected: status %0d channel %0d",
                                m_tuser, m_tdata[2:0]));
    end else begin
      want   = ack_queue.pop_front();
      got_f  = '{32'(m_tuser), 32'(m_tdata[2:0]), 32'(m_tdata[3]), m_tdata[35:4],
                 32'(m_tdata[51:36]), 32'(m_tdata[59:52]), 32'(m_tlast)};
      want_f = '{32'(want.status), 32'(want.ch), 32'(want.val), want.ver,
                 32'(want.tag), 32'(want.pins), 32'(want.last)};
      for (int i = 0; i < 7; i++) begin
        if (got_f[i] !== want_f[i]) begin
          report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h (status %0d, channel %0d)",
                                    field_name[i], got_f[i], want_f[i], want.status, want.ch));
        end
      end
      status_seen[want.status]++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample all handshakes at the rising edge. Check results before
  // predicting, so a result always meets the expectations of earlier beats.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    command_beat_t b;
    if (rst_ni) begin
      s_taken = s_tvalid && s_tready;
      if (m_tvalid && m_tready) check_ack();
      if (s_taken) begin
        b.op  = op_e'(s_tuser);
        b.ch  = s_tdata[2:0];
        b.val = s_tdata[3];
        b.ver = s_tdata[35:4];
        b.tag = s_tdata[51:36];
        b.now = s_tdata[83:52];
        predict_acks(b);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_CHANNEL_COUNT: cfg_count    = cfg_data_i[3:0];
          CFG_ACTIVE_HIGH:   cfg_polarity = cfg_data_i[7:0];
          CFG_INTERVAL_LO:   gap_lo       = cfg_data_i;
          CFG_INTERVAL_HI:   gap_hi       = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Watchdog: end the run if nothing moves on any channel for too long.
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid_i && cfg_ready_o)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("Timeout: no beat for %0d cycles, %0d results still expected",
               QUIET_LIMIT, ack_queue.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Slave-side driver: hold a beat until it is taken, then wait out a gap and
  // present the next pending command. Drives on the falling edge only.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_commands
    command_beat_t b;
    if (rst_ni && !(s_tvalid && !s_taken)) begin
      if (send_wait != 0) begin
        s_tvalid <= 1'b0;
        send_wait--;
      end else if (cmd_queue.size() != 0) begin
        b = cmd_queue.pop_front();
        s_tuser  <= b.op;
        s_tdata  <= {4'b0, b.now, b.tag, b.ver, b.val, b.ch};
        s_tvalid <= 1'b1;
        send_wait = pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Master-side back-pressure: stall now and then for a random stretch.
  always @(negedge clk_i) begin : drive_ready
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
    end
  end

  function automatic void push_beat(op_e op, logic [2:0] ch, logic val, logic [31:0] ver,
                                    logic [15:0] tag, logic [31:0] now);
    command_beat_t b;
    b.op  = op;
    b.ch  = ch;
    b.val = val;
    b.ver = ver;
    b.tag = tag;
    b.now = now;
    cmd_queue.push_back(b);
    if (op == OP_WRITE) n_writes++;
    else n_ticks++;
  endfunction

  // Wait until every command has gone in and every result has come out.
  task automatic drain();
    do @(posedge clk_i);
    while (cmd_queue.size() != 0 || s_tvalid || ack_queue.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
  endtask

  // Write all four registers back to back, then release the channel.
  task automatic configure(logic [3:0] count, logic [7:0] mask, logic [63:0] lo,
                           logic [63:0] hi);
    write_reg(CFG_CHANNEL_COUNT, {60'd0, count});
    write_reg(CFG_ACTIVE_HIGH, {56'd0, mask});
    write_reg(CFG_INTERVAL_LO, lo);
    write_reg(CFG_INTERVAL_HI, hi);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly intervals comparable to the time steps, plus the extremes.
  function automatic logic [63:0] random_intervals();
    logic [63:0] word;
    int unsigned r;
    for (int lane = 0; lane < 4; lane++) begin
      r = $urandom_range(0, 9);
      if (r < 4) word[lane*16 +: 16] = 16'($urandom_range(1, 20));
      else if (r < 7) word[lane*16 +: 16] = 16'($urandom_range(21, 60));
      else if (r < 8) word[lane*16 +: 16] = 16'd0;
      else if (r < 9) word[lane*16 +: 16] = 16'hFFFF;
      else word[lane*16 +: 16] = 16'($urandom);
    end
    return word;
  endfunction

  // Random traffic: rising versions per channel with some stale, unversioned
  // and wild ones; time advancing mostly in small steps; about a quarter ticks.
  task automatic add_random_items(int unsigned count, int unsigned lanes);
    int unsigned r;
    logic [2:0]  ch;
    logic [31:0] ver;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) clock_ms += $urandom_range(0, 6);
      else if (r < 95) clock_ms += $urandom_range(0, 40);
      else clock_ms += $urandom;
      ch = (lanes != 0 && $urandom_range(0, 9) != 0) ? 3'($urandom_range(0, lanes - 1))
                                                    : 3'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        push_beat(OP_TICK, ch, 1'($urandom), $urandom, 16'($urandom), clock_ms);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          issued_ver[ch] += $urandom_range(1, 3);
          ver = issued_ver[ch];
        end else if (r < 78) begin
          ver = '0;
        end else if (r < 90) begin
          ver = (issued_ver[ch] > 2) ? issued_ver[ch] - $urandom_range(0, 2) : issued_ver[ch];
        end else begin
          ver = $urandom;
          issued_ver[ch] = ver;
        end
        push_beat(OP_WRITE, ch, 1'($urandom), ver, 16'($urandom), clock_ms);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [3:0] count;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: no channel in use, so writes bounce and ticks idle.
    push_beat(OP_WRITE, 3'd2, 1'b1, 32'd1, 16'h1234, 32'd0);
    push_beat(OP_TICK, 3'd0, 1'b0, 32'd0, 16'd0, 32'd0);
    drain();
    configure(4'd0, 8'hFF, '1, '1);
    push_beat(OP_WRITE, 3'd0, 1'b1, 32'd0, 16'hABCD, 32'd5);
    drain();

    // All eight channels, mixed polarity; intervals:
    // ch0 100, ch1 max, ch2 5, ch3 0, ch4 1, ch5 30, ch6 max, ch7 16.
    configure(4'd8, 8'hA5, {16'd0, 16'd5, 16'hFFFF, 16'd100},
              {16'd16, 16'hFFFF, 16'd30, 16'd1});
    // First write on a fresh channel applies; next one inside the interval defers.
    push_beat(OP_WRITE, 3'd0, 1'b1, 32'd0, 16'hFFFF, 32'd0);
    push_beat(OP_WRITE, 3'd0, 1'b0, 32'd5, 16'd1, 32'd1);
    // Equal and older versions drop as stale and leave the pending command alone.
    push_beat(OP_WRITE, 3'd0, 1'b1, 32'd5, 16'd2, 32'd2);
    push_beat(OP_WRITE, 3'd0, 1'b1, 32'd3, 16'd3, 32'd3);
    push_beat(OP_TICK, 3'd7, 1'b1, '1, 16'hFFFF, 32'd50);
    // Top version, then an unversioned defer that resets it, then a replacement.
    push_beat(OP_WRITE, 3'd2, 1'b1, 32'hFFFF_FFFF, 16'h8000, 32'd50);
    push_beat(OP_WRITE, 3'd2, 1'b0, 32'd0, 16'd4, 32'd52);
    push_beat(OP_WRITE, 3'd2, 1'b1, 32'd1, 16'd5, 32'd53);
    // Zero interval: back-to-back writes at the same time both apply.
    push_beat(OP_WRITE, 3'd3, 1'b1, 32'd7, 16'd6, 32'd53);
    push_beat(OP_WRITE, 3'd3, 1'b0, 32'd8, 16'd7, 32'd53);
    push_beat(OP_WRITE, 3'd5, 1'b1, 32'd2, 16'd8, 32'd40);
    push_beat(OP_WRITE, 3'd5, 1'b0, 32'd3, 16'd9, 32'd60);
    // Tick that flushes three channels in one burst.
    push_beat(OP_TICK, 3'd0, 1'b0, 32'd0, 16'd0, 32'd100);
    // Time wrap: defer just before the wrap, flush just after it.
    push_beat(OP_WRITE, 3'd7, 1'b1, 32'd10, 16'd10, 32'hFFFF_FFF0);
    push_beat(OP_WRITE, 3'd7, 1'b0, 32'd11, 16'd11, 32'hFFFF_FFF5);
    push_beat(OP_TICK, 3'd0, 1'b0, 32'd0, 16'd0, 32'd2);
    // Longest interval: leave a command waiting on ch6.
    push_beat(OP_WRITE, 3'd6, 1'b1, 32'd1, 16'd12, 32'd2);
    push_beat(OP_WRITE, 3'd6, 1'b0, 32'd2, 16'd13, 32'h0000_1000);
    push_beat(OP_WRITE, 3'd4, 1'b1, 32'd0, 16'd14, 32'h0000_1000);
    drain();

    // Three channels in use: ch6 keeps its pending command through a tick.
    configure(4'd3, 8'h3C, {4{16'hFFFF}}, {16'd16, 16'hFFFF, 16'd30, 16'd1});
    push_beat(OP_WRITE, 3'd6, 1'b1, 32'd9, 16'd15, 32'h0000_2000);
    push_beat(OP_WRITE, 3'd3, 1'b1, 32'd9, 16'd16, 32'h0000_2000);
    push_beat(OP_WRITE, 3'd1, 1'b1, 32'd1, 16'd17, 32'h0000_2000);
    push_beat(OP_TICK, 3'd0, 1'b0, 32'd0, 16'd0, 32'h0002_0000);
    drain();

    // Count above eight saturates: the held ch6 command now flushes.
    configure(4'd15, 8'h00, '0, {16'd16, 16'hFFFF, 16'd30, 16'd1});
    push_beat(OP_TICK, 3'd0, 1'b0, 32'd0, 16'd0, 32'h0002_0000);
    push_beat(OP_WRITE, 3'd1, 1'b0, 32'd0, 16'd18, 32'h0002_0000);
    drain();

    // Random phases: full, partial, saturated and full again; the partial one
    // runs without any idling on either side.
    clock_ms = $urandom;
    for (int p = 0; p < 4; p++) begin
      case (p)
        1:       count = 4'($urandom_range(1, 7));
        2:       count = 4'($urandom_range(9, 15));
        default: count = 4'd8;
      endcase
      idle_on = (p != 1);
      configure(count, 8'($urandom), random_intervals(), random_intervals());
      add_random_items(30, (count > CHANNELS) ? CHANNELS : count);
      drain();
    end

    $display("Covered %0d writes and %0d ticks: %0d applied, %0d deferred, %0d stale,",
             n_writes, n_ticks, status_seen[STATUS_APPLIED], status_seen[STATUS_DEFERRED],
             status_seen[STATUS_STALE]);
    $display("  %0d unmapped, %0d idle ticks; %0d mismatches",
             status_seen[STATUS_UNMAPPED], status_seen[STATUS_NONE_DUE], error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
